/* rtl/chp_pkg.sv */
// ----------------------------------------------------------------------------
// chp_pkg
// shared constants, codes and helpers of the complex polynomial evaluator
// ----------------------------------------------------------------------------
package chp_pkg;

   localparam int COEF_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int DEGREE_W = 4;
   localparam int INDEX_W  = 4;
   localparam int WORD_W   = 32;
   localparam int WIDE_W   = 66;

   // request kind carried on tuser
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_MUL,
      S_RND,
      S_ADD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              flag;
      logic [WORD_W-1:0] val;
   } sat_type;

   localparam logic signed [WIDE_W-1:0] WORD_MAX = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] WORD_MIN = -66'sd2147483648;

   // clip a wide signed value to the 32-bit signed range
   function automatic sat_type sat_word(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > WORD_MAX) begin
         r.flag = 1'b1;
         r.val  = WORD_MAX[WORD_W-1:0];
      end else if (v < WORD_MIN) begin
         r.flag = 1'b1;
         r.val  = WORD_MIN[WORD_W-1:0];
      end else begin
         r.flag = 1'b0;
         r.val  = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/chp_ram.sv */
// ----------------------------------------------------------------------------
// chp_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module chp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/complex_poly_horner_eval.sv */
// ----------------------------------------------------------------------------
// complex_poly_horner_eval
// horner evaluation of a real-coefficient polynomial at a complex point
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one signed Q16.16 coefficient into the
// coefficient ram in the cycle it is taken and gives no result; loads at an
// index beyond the ram depth are dropped. An evaluate beat (tuser = 1) brings
// x and gives one result beat p(x) = sum a[i] x^i over i = 0..degree, where
// degree is the csr register (reset 0); a degree of zero gives 0 + 0i.
// An evaluate runs a per-coefficient loop in the states S_MUL, S_RND and
// S_ADD: four 32x32 products, then rounding to nearest (ties up) with
// saturation, then the coefficient add with saturation. One item is in
// work at a time; a finished result sits in the output register so the
// next request can be taken while it waits. Coefficients must be loaded
// before use: unwritten ram entries read as garbage. The saturated flag
// is set if any step clipped. Configuration is to be written only while
// the block is idle.
// ----------------------------------------------------------------------------
module complex_poly_horner_eval #(
   parameter int COEF_DEPTH = chp_pkg::COEF_DEPTH_DEF,
   parameter int FRAC_BITS  = chp_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request beat
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // coef_index[3:0], coef_value[35:4], x_re[67:36], x_im[99:68], zero pad
   input  logic [103:0]                  req_tdata,
   // operation[0]
   input  logic [0:0]                    req_tuser,
   // result beat
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // p_re[31:0], p_im[63:32]
   output logic [63:0]                   rsp_tdata,
   // saturated[0]
   output logic [0:0]                    rsp_tuser,
   // degree register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [chp_pkg::DEGREE_W-1:0]  csr_data
);

   import chp_pkg::*;

   localparam int AW = $clog2(COEF_DEPTH);
   localparam logic signed [WIDE_W-1:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   // request fields
   logic [INDEX_W-1:0]        req_index;
   logic signed [WORD_W-1:0]  req_value;
   logic signed [WORD_W-1:0]  req_x_re;
   logic signed [WORD_W-1:0]  req_x_im;
   logic                      req_take;
   logic                      req_eval;

   assign req_index = req_tdata[3:0];
   assign req_value = req_tdata[35:4];
   assign req_x_re  = req_tdata[67:36];
   assign req_x_im  = req_tdata[99:68];
   assign req_take  = req_tvalid & req_tready;
   assign req_eval  = (op_type'(req_tuser[0]) == OP_EVAL);

   // control state
   state_type               state_ff, state_in;
   logic [DEGREE_W-1:0]     degree_ff;
   logic [DEGREE_W-1:0]     cnt_ff, cnt_in;
   logic                    flag_ff, flag_in;
   logic                    rd_ok_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [WORD_W-1:0] x_re_ff, x_re_in;
   logic signed [WORD_W-1:0] x_im_ff, x_im_in;
   logic signed [WORD_W-1:0] p_re_ff, p_re_in;
   logic signed [WORD_W-1:0] p_im_ff, p_im_in;
   logic signed [WORD_W-1:0] m_re_ff, m_re_in;
   logic signed [WORD_W-1:0] m_im_ff, m_im_in;
   logic signed [63:0]       rr_ff, ii_ff, ri_ff, ir_ff;
   logic [63:0]              rsp_data_ff, rsp_data_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // ram ports
   logic                 wr_en;
   logic [31:0]          wr_idx32;
   logic [DEGREE_W-1:0]  rd_idx;
   logic [31:0]          rd_idx32;
   logic [WORD_W-1:0]    ram_rd_data;
   logic signed [WORD_W-1:0] coef_rd;

   // control decodes
   logic out_free;
   logic ld_first, ld_mul, ld_rnd, ld_add, ld_out, ld_zero;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
      end else if (csr_valid & csr_ready) begin
         degree_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // coefficient ram: writes happen only in idle, read data is used only
   // while an evaluate is in work, so the fsm keeps the two from overlapping
   // ------------------------------------------------------------------
   assign wr_idx32 = 32'(req_index);
   assign wr_en    = req_take & ~req_eval & (wr_idx32 < 32'(COEF_DEPTH));

   // read index: degree on the accept, the next lower index afterwards
   assign rd_idx   = (state_ff == S_IDLE) ? degree_ff : cnt_ff - 4'd1;
   assign rd_idx32 = 32'(rd_idx);

   chp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx32[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_idx32[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // index beyond the ram depth reads as zero
   always_ff @(posedge clock) begin
      rd_ok_ff <= (rd_idx32 < 32'(COEF_DEPTH));
   end

   assign coef_rd = rd_ok_ff ? signed'(ram_rd_data) : '0;

   // ------------------------------------------------------------------
   // state machine
   // ------------------------------------------------------------------
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take & req_eval) begin
               state_in = (degree_ff == '0) ? S_DONE : S_FIRST;
            end
         end
         S_FIRST: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_RND;
         end
         S_RND: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            state_in = (cnt_ff == 4'd1) ? S_DONE : S_MUL;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ld_zero    = 1'b0;
      ld_first   = 1'b0;
      ld_mul     = 1'b0;
      ld_rnd     = 1'b0;
      ld_add     = 1'b0;
      ld_out     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ld_zero    = req_take & req_eval;
         end
         S_FIRST: begin
            ld_first = 1'b1;
         end
         S_MUL: begin
            ld_mul = 1'b1;
         end
         S_RND: begin
            ld_rnd = 1'b1;
         end
         S_ADD: begin
            ld_add = 1'b1;
         end
         S_DONE: begin
            ld_out = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // datapath: multiply, round and clip, add coefficient and clip
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ld_mul) begin
         rr_ff <= p_re_ff * x_re_ff;
         ii_ff <= p_im_ff * x_im_ff;
         ri_ff <= p_re_ff * x_im_ff;
         ir_ff <= p_im_ff * x_re_ff;
      end
   end

   logic signed [WIDE_W-1:0] sum_re, sum_im, sum_add;
   sat_type                  sat_re, sat_im, sat_add;

   always_comb begin
      sum_re  = (66'(rr_ff) - 66'(ii_ff) + HALF) >>> FRAC_BITS;
      sum_im  = (66'(ri_ff) + 66'(ir_ff) + HALF) >>> FRAC_BITS;
      sum_add = 66'(m_re_ff) + 66'(coef_rd);
      sat_re  = sat_word(sum_re);
      sat_im  = sat_word(sum_im);
      sat_add = sat_word(sum_add);
   end

   always_comb begin
      x_re_in      = x_re_ff;
      x_im_in      = x_im_ff;
      p_re_in      = p_re_ff;
      p_im_in      = p_im_ff;
      m_re_in      = m_re_ff;
      m_im_in      = m_im_ff;
      cnt_in       = cnt_ff;
      flag_in      = flag_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (ld_zero) begin
         x_re_in = req_x_re;
         x_im_in = req_x_im;
         p_re_in = '0;
         p_im_in = '0;
         cnt_in  = degree_ff;
         flag_in = 1'b0;
      end
      if (ld_first) begin
         // start from the top coefficient
         p_re_in = coef_rd;
         p_im_in = '0;
      end
      if (ld_rnd) begin
         m_re_in = signed'(sat_re.val);
         m_im_in = signed'(sat_im.val);
         flag_in = flag_ff | sat_re.flag | sat_im.flag;
      end
      if (ld_add) begin
         p_re_in = signed'(sat_add.val);
         p_im_in = m_im_ff;
         flag_in = flag_ff | sat_add.flag;
         cnt_in  = cnt_ff - 4'd1;
      end
      if (ld_out) begin
         rsp_data_in  = {p_im_ff, p_re_ff};
         rsp_sat_in   = flag_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_re_ff     <= x_re_in;
      x_im_ff     <= x_im_in;
      p_re_ff     <= p_re_in;
      p_im_ff     <= p_im_in;
      m_re_ff     <= m_re_in;
      m_im_ff     <= m_im_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------

   // a new result beat only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result beat raised outside done state");

   // a finished result waits while the output register is still held
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_tready) |=> state_ff == S_DONE)
      else $error("done state left while output register busy");

   // the step counter never reaches zero inside the horner loop
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_RND || state_ff == S_ADD) |-> cnt_ff != '0)
      else $error("step counter empty inside loop");

   // no coefficient write while an evaluate is in work
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_IDLE)
      else $error("coefficient write outside idle");

endmodule
